// ===== sv/command_packet_loader_top_assert.svh =====
// Assertion macros shared by the command packet loader modules.
// Uses i_clk and i_rst_n of the including module; no other dependencies.
`ifndef COMMAND_PACKET_LOADER_TOP_ASSERT_SVH
`define COMMAND_PACKET_LOADER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Property checked at every clock edge outside reset.
`define CPL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("%m: assertion failed");
// Plain expression that must hold at every clock edge outside reset.
`define CPL_ASSERT_ALWAYS(lbl, expr) \
    `CPL_ASSERT(lbl, 1'b1 |-> (expr))
`else
`define CPL_ASSERT(lbl, prop)
`define CPL_ASSERT_ALWAYS(lbl, expr)
`endif

`endif

// ===== sv/cpl_pkg.sv =====
// Package of the command packet loader: item structs, result codes and labels.
// No dependencies; imported by every module of the block.
package cpl_pkg;

    // One input item: a packet byte and the end-of-transfer flag.
    typedef struct packed {
        logic [7:0] packet_byte;
        logic       end_of_transfer;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [2:0]  kind;
        logic [11:0] element_index;
        logic [3:0]  setting_id;
        logic [31:0] data_word;
        logic [2:0]  status;
        logic        last_of_run;
    } t_out_item;

    // Up to two results caused by one accepted byte; valid[1] implies valid[0].
    typedef struct packed {
        logic [1:0] valid;
        t_out_item  res0;
        t_out_item  res1;
    } t_res_pair;

    // Result kinds.
    localparam logic [2:0] KIND_X    = 3'd0;
    localparam logic [2:0] KIND_Y    = 3'd1;
    localparam logic [2:0] KIND_TRIG = 3'd2;
    localparam logic [2:0] KIND_SET  = 3'd3;
    localparam logic [2:0] KIND_STAT = 3'd4;

    // Packet status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_CHECKSUM = 3'd1;
    localparam logic [2:0] ST_PACKET   = 3'd2;
    localparam logic [2:0] ST_STORE    = 3'd3;
    localparam logic [2:0] ST_LABEL    = 3'd4;
    localparam logic [2:0] ST_EARLY    = 3'd5;

    // Setting numbers.
    localparam logic [3:0] SET_LENGTH   = 4'd0;
    localparam logic [3:0] SET_SCANS    = 4'd1;
    localparam logic [3:0] SET_LOWPASS  = 4'd2;
    localparam logic [3:0] SET_TSTART   = 4'd3;
    localparam logic [3:0] SET_TPERIOD  = 4'd4;
    localparam logic [3:0] SET_TLENGTH  = 4'd5;
    localparam logic [3:0] SET_XSTARTV  = 4'd6;
    localparam logic [3:0] SET_YSTARTV  = 4'd7;
    localparam logic [3:0] SET_XSTOPV   = 4'd8;
    localparam logic [3:0] SET_YSTOPV   = 4'd9;

    // Label bytes.
    localparam logic [7:0] LBL_X = "x";
    localparam logic [7:0] LBL_Y = "y";
    localparam logic [7:0] LBL_L = "l";
    localparam logic [7:0] LBL_C = "c";
    localparam logic [7:0] LBL_F = "f";
    localparam logic [7:0] LBL_T = "t";
    localparam logic [7:0] LBL_S = "s";
    localparam logic [7:0] LBL_P = "p";
    localparam logic [7:0] LBL_N = "n";
    localparam logic [7:0] LBL_A = "a";
    localparam logic [7:0] LBL_B = "b";
    localparam logic [7:0] LBL_E = "e";

    // Depth of the result queue; a byte is taken only with room for two results.
    localparam int RES_DEPTH = 4;

endpackage

// ===== sv/cpl_parser.sv =====
// Packet parser of the command packet loader: state per byte and result generation.
// Depends on cpl_pkg and command_packet_loader_top_assert.svh.
`include "command_packet_loader_top_assert.svh"

module cpl_parser
    import cpl_pkg::*;
#(
    parameter int STORE_DEPTH  = 4096,
    parameter int PACKET_BYTES = 512
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_take,
    input  t_in_item  i_item,
    output t_res_pair o_res
);

    localparam int W_CNT = $clog2(PACKET_BYTES);
    localparam logic [34:0] PKT_LIMIT   = 35'(PACKET_BYTES);
    localparam logic [32:0] STORE_LIMIT = 33'(STORE_DEPTH);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LABEL2,
        PH_HEADER,
        PH_PAYLOAD,
        PH_DISCARD
    } t_phase;

    typedef enum logic [2:0] {
        PT_X, PT_Y, PT_T, PT_L, PT_C, PT_F, PT_B, PT_E
    } t_ptype;

    t_phase           r_phase, n_phase;
    logic [3:0]       r_pos, n_pos;
    t_ptype           r_ptype, n_ptype;
    logic [7:0]       r_label2, n_label2;
    logic [15:0]      r_rsum, n_rsum;
    logic [15:0]      r_lsum, n_lsum;
    logic [31:0]      r_start, n_start;
    logic [31:0]      r_total, n_total;
    logic [31:0]      r_word, n_word;
    logic [W_CNT-1:0] r_wr, n_wr;

    logic [7:0]   byte_in;
    logic         eot;
    logic         is_trig;
    logic         is_stream;
    logic [15:0]  lsum_add;
    logic         chk_bad;
    logic [31:0]  hdr_total;
    logic [34:0]  bytes_need;
    logic         over_pkt;
    logic         over_store;
    logic [31:0]  word_next;
    logic [W_CNT:0] wr_inc;
    logic [3:0]   set_id;
    logic         done;
    logic         quiet;
    logic         label_ok;
    logic [1:0]   v;
    t_out_item    res0, res1;

    function automatic t_out_item mk_res(input logic [2:0] kind, input logic [11:0] idx,
                                         input logic [3:0] sid, input logic [31:0] data,
                                         input logic [2:0] st);
        t_out_item it;
        it.kind          = kind;
        it.element_index = idx;
        it.setting_id    = sid;
        it.data_word     = data;
        it.status        = st;
        it.last_of_run   = 1'b0;
        return it;
    endfunction

    // Shared per-byte terms.
    assign byte_in   = i_item.packet_byte;
    assign eot       = i_item.end_of_transfer;
    assign is_trig   = (r_ptype == PT_T) && (r_label2 == LBL_A);
    assign is_stream = (r_ptype == PT_X) || (r_ptype == PT_Y) || is_trig;
    assign lsum_add  = r_pos[0] ? {8'h00, byte_in} : {byte_in, 8'h00};
    assign chk_bad   = (16'(r_lsum + lsum_add) != r_rsum);
    assign hdr_total = {r_total[23:0], byte_in};
    assign word_next = {r_word[23:0], byte_in};
    assign wr_inc    = {1'b0, r_wr} + (W_CNT+1)'(1);

    // Size checks on the completed header.
    assign bytes_need = ({3'b000, hdr_total} << (is_trig ? 2 : 1)) + 35'd12;
    assign over_pkt   = bytes_need > PKT_LIMIT;
    assign over_store = ({1'b0, r_start} + {1'b0, hdr_total}) > STORE_LIMIT;

    // Setting number from the two labels.
    always_comb begin
        unique case (r_ptype)
            PT_L: set_id = SET_LENGTH;
            PT_C: set_id = SET_SCANS;
            PT_F: set_id = SET_LOWPASS;
            PT_T: set_id = (r_label2 == LBL_S) ? SET_TSTART :
                           ((r_label2 == LBL_P) ? SET_TPERIOD : SET_TLENGTH);
            PT_B: set_id = (r_label2 == LBL_X) ? SET_XSTARTV : SET_YSTARTV;
            default: set_id = (r_label2 == LBL_X) ? SET_XSTOPV : SET_YSTOPV;
        endcase
    end

    // Next state and the results of the current byte.
    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_ptype  = r_ptype;
        n_label2 = r_label2;
        n_rsum   = r_rsum;
        n_lsum   = r_lsum;
        n_start  = r_start;
        n_total  = r_total;
        n_word   = r_word;
        n_wr     = r_wr;
        v        = 2'b00;
        res0     = '0;
        res1     = '0;
        done     = 1'b0;
        quiet    = 1'b0;
        label_ok = 1'b1;

        unique case (r_phase)
            PH_IDLE: begin
                n_pos    = 4'd1;
                n_label2 = 8'h00;
                n_rsum   = 16'h0000;
                n_start  = 32'h0;
                n_total  = 32'h0;
                n_word   = 32'h0;
                n_wr     = '0;
                n_lsum   = {byte_in, 8'h00};
                unique case (byte_in)
                    LBL_X: n_ptype = PT_X;
                    LBL_Y: n_ptype = PT_Y;
                    LBL_T: n_ptype = PT_T;
                    LBL_L: n_ptype = PT_L;
                    LBL_C: n_ptype = PT_C;
                    LBL_F: n_ptype = PT_F;
                    LBL_B: n_ptype = PT_B;
                    LBL_E: n_ptype = PT_E;
                    default: begin
                        n_ptype = PT_X;
                        res0    = mk_res(KIND_STAT, 12'h0, 4'h0, 32'h0, ST_LABEL);
                        v       = 2'b01;
                        done    = 1'b1;
                    end
                endcase
                if (!done) begin
                    n_phase = PH_LABEL2;
                end
            end
            PH_LABEL2: begin
                n_label2 = byte_in;
                n_lsum   = r_lsum + {8'h00, byte_in};
                n_pos    = 4'd2;
                if (r_ptype == PT_T) begin
                    label_ok = (byte_in == LBL_A) || (byte_in == LBL_S) ||
                               (byte_in == LBL_P) || (byte_in == LBL_N);
                end else if ((r_ptype == PT_B) || (r_ptype == PT_E)) begin
                    label_ok = (byte_in == LBL_X) || (byte_in == LBL_Y);
                end
                if (label_ok) begin
                    n_phase = PH_HEADER;
                end else begin
                    res0 = mk_res(KIND_STAT, 12'h0, 4'h0, 32'h0, ST_LABEL);
                    v    = 2'b01;
                    done = 1'b1;
                end
            end
            PH_HEADER: begin
                if (r_pos == 4'd2) begin
                    n_rsum = {byte_in, 8'h00};
                end else if (r_pos == 4'd3) begin
                    n_rsum = {r_rsum[15:8], byte_in};
                end else begin
                    n_lsum = r_lsum + lsum_add;
                    if (r_pos < 4'd8) begin
                        n_start = {r_start[23:0], byte_in};
                    end else begin
                        n_total = hdr_total;
                    end
                end
                n_pos = r_pos + 4'd1;
                if (!is_stream && (r_pos == 4'd7)) begin
                    // Parameter packet: setting only when the checksum matches.
                    if (!chk_bad) begin
                        res0 = mk_res(KIND_SET, 12'h0, set_id, {r_start[23:0], byte_in}, ST_OK);
                        res1 = mk_res(KIND_STAT, 12'h0, 4'h0, 32'h0, ST_OK);
                        v    = 2'b11;
                    end else begin
                        res0 = mk_res(KIND_STAT, 12'h0, 4'h0, 32'h0, ST_CHECKSUM);
                        v    = 2'b01;
                    end
                    done = 1'b1;
                end else if (is_stream && (r_pos == 4'd11)) begin
                    if (over_pkt) begin
                        res0 = mk_res(KIND_STAT, 12'h0, 4'h0, 32'h0, ST_PACKET);
                        v    = 2'b01;
                        done = 1'b1;
                    end else if (over_store) begin
                        res0 = mk_res(KIND_STAT, 12'h0, 4'h0, 32'h0, ST_STORE);
                        v    = 2'b01;
                        done = 1'b1;
                    end else if (hdr_total == 32'h0) begin
                        res0 = mk_res(KIND_STAT, 12'h0, 4'h0, 32'h0,
                                      chk_bad ? ST_CHECKSUM : ST_OK);
                        v    = 2'b01;
                        done = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                // Elements end on odd positions (waveform) or every fourth byte (trigger).
                n_lsum = r_lsum + lsum_add;
                n_word = word_next;
                n_pos  = r_pos + 4'd1;
                if (is_trig ? (r_pos[1:0] == 2'b11) : r_pos[0]) begin
                    res0 = mk_res(is_trig ? KIND_TRIG : ((r_ptype == PT_Y) ? KIND_Y : KIND_X),
                                  12'(r_start[11:0] + 12'(r_wr)), 4'h0,
                                  is_trig ? word_next : {16'h0000, word_next[15:0]}, ST_OK);
                    v      = 2'b01;
                    n_word = 32'h0;
                    n_wr   = wr_inc[W_CNT-1:0];
                    if (32'(wr_inc) >= r_total) begin
                        res1 = mk_res(KIND_STAT, 12'h0, 4'h0, 32'h0,
                                      chk_bad ? ST_CHECKSUM : ST_OK);
                        v    = 2'b11;
                        done = 1'b1;
                    end
                end
            end
            PH_DISCARD: begin
                quiet = 1'b1;
                if (eot) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                quiet   = 1'b1;
                n_phase = PH_IDLE;
            end
        endcase

        // Packet end handling: trailing bytes are dropped, a short packet ends early.
        if (!quiet) begin
            if (done) begin
                n_phase = eot ? PH_IDLE : PH_DISCARD;
            end else if (eot) begin
                if (v[0]) begin
                    res1 = mk_res(KIND_STAT, 12'h0, 4'h0, 32'h0, ST_EARLY);
                    v    = 2'b11;
                end else begin
                    res0 = mk_res(KIND_STAT, 12'h0, 4'h0, 32'h0, ST_EARLY);
                    v    = 2'b01;
                end
                n_phase = PH_IDLE;
            end
        end

        // Flag the last result of this byte.
        if (v == 2'b01) begin
            res0.last_of_run = 1'b1;
        end else if (v == 2'b11) begin
            res1.last_of_run = 1'b1;
        end
    end

    assign o_res.valid = i_take ? v : 2'b00;
    assign o_res.res0  = res0;
    assign o_res.res1  = res1;

    // Parser state, updated on each accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_pos    <= 4'd0;
            r_ptype  <= PT_X;
            r_label2 <= 8'h00;
            r_rsum   <= 16'h0000;
            r_lsum   <= 16'h0000;
            r_start  <= 32'h0;
            r_total  <= 32'h0;
            r_word   <= 32'h0;
            r_wr     <= '0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_ptype  <= n_ptype;
            r_label2 <= n_label2;
            r_rsum   <= n_rsum;
            r_lsum   <= n_lsum;
            r_start  <= n_start;
            r_total  <= n_total;
            r_word   <= n_word;
            r_wr     <= n_wr;
        end
    end

    // Payload bytes only ever follow a header of a waveform or trigger packet.
    `CPL_ASSERT_ALWAYS(a_payload_is_stream, (r_phase != PH_PAYLOAD) || is_stream)
    // A lone result carries the last-of-run flag.
    `CPL_ASSERT(a_last_single, (o_res.valid == 2'b01) |-> o_res.res0.last_of_run)
    // With two results only the second one is flagged last.
    `CPL_ASSERT(a_last_pair,
        (o_res.valid == 2'b11) |-> (!o_res.res0.last_of_run && o_res.res1.last_of_run))

endmodule

// ===== sv/cpl_fifo.sv =====
// Result queue of the command packet loader: takes up to two results a cycle,
// gives one a cycle while i_ready is high. Depends on cpl_pkg and command_packet_loader_top_assert.svh.
`include "command_packet_loader_top_assert.svh"

module cpl_fifo
    import cpl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_res_pair i_res,
    output logic      o_room,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    localparam int W_PTR = $clog2(RES_DEPTH);
    localparam int W_CNT = $clog2(RES_DEPTH + 1);

    t_out_item        r_mem [RES_DEPTH];
    logic [W_PTR-1:0] r_wr_ptr, n_wr_ptr;
    logic [W_PTR-1:0] r_rd_ptr, n_rd_ptr;
    logic [W_CNT-1:0] r_count, n_count;
    logic             pop;
    logic [W_CNT-1:0] push_n;
    logic [W_PTR-1:0] wr_ptr1;

    // Room is kept for the worst case of two results from one byte.
    assign o_room  = (r_count <= W_CNT'(RES_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;
    assign push_n  = W_CNT'(i_res.valid[0]) + W_CNT'(i_res.valid[1]);
    assign wr_ptr1 = r_wr_ptr + W_PTR'(1);

    // Pointer and fill count arithmetic.
    always_comb begin
        n_wr_ptr = r_wr_ptr + W_PTR'(push_n);
        n_rd_ptr = pop ? (r_rd_ptr + W_PTR'(1)) : r_rd_ptr;
        n_count  = r_count + push_n - W_CNT'(pop);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Result storage; a byte writes its results at two consecutive entries.
    always_ff @(posedge i_clk) begin
        if (i_res.valid[0]) begin
            r_mem[r_wr_ptr] <= i_res.res0;
        end
        if (i_res.valid[1]) begin
            r_mem[wr_ptr1] <= i_res.res1;
        end
    end

    `CPL_ASSERT_ALWAYS(a_count_bound, r_count <= W_CNT'(RES_DEPTH))
    // Results only arrive when two entries are free.
    `CPL_ASSERT(a_push_room, (i_res.valid != 2'b00) |-> (r_count <= W_CNT'(RES_DEPTH - 2)))
    // Results fill the first slot before the second.
    `CPL_ASSERT(a_push_order, i_res.valid[1] |-> i_res.valid[0])

endmodule

// ===== sv/command_packet_loader_top.sv =====
// Top level of the command packet loader: input handshake, parser and result queue.
// Depends on cpl_pkg, cpl_parser and cpl_fifo.
//
// Usage: packet bytes enter on the input channel (i_in_valid / o_in_ready,
// payload i_in_item with packet_byte and end_of_transfer). Each byte causes
// zero, one or two result items on the output channel (o_out_valid /
// i_out_ready, payload o_out_item): x, y and trigger buffer writes, settings,
// and one packet status per packet, the last result of a byte flagged with
// last_of_run.
// The results of a byte are written to the result queue as it is accepted.
// Throughput: one byte per cycle while the queue has room; the parser does all
// per-byte work combinationally. The output drains one result per cycle while
// i_out_ready is high, so the output limits bytes that cause two results.
// A four-entry result queue sits between parser and output; o_in_ready is
// high while it has room for two results, so a stalled receiver fills the
// queue and then holds off input with no result lost.
// Reset (synchronous, active low) empties the queue and waits for the first
// label byte of a new packet; no clearing pass is needed.
module command_packet_loader_top
    import cpl_pkg::*;
#(
    parameter int STORE_DEPTH  = 4096,
    parameter int PACKET_BYTES = 512
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      w_room;
    logic      w_take;
    t_res_pair w_res;

    // A byte is taken whenever the queue can hold all that it may cause.
    assign o_in_ready = w_room;
    assign w_take     = i_in_valid && w_room;

    cpl_parser #(
        .STORE_DEPTH  (STORE_DEPTH),
        .PACKET_BYTES (PACKET_BYTES)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_item  (i_in_item),
        .o_res   (w_res)
    );

    cpl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (w_res),
        .o_room  (w_room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

// ===== tb/cpl_packet_checker.sv =====
// Checker of the command packet loader: predicts the results of every accepted byte
// and compares them, field by field and in order, with the output channel.
// Depends on cpl_pkg; instantiated beside the block by command_packet_loader_top_tb.
module cpl_packet_checker
    import cpl_pkg::*;
#(
    parameter int STORE_DEPTH  = 4096,
    parameter int PACKET_BYTES = 512
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_errors,
    output int        o_pending,
    output int        o_checked
);

    typedef enum logic [2:0] {
        PH_WAIT_LABEL,
        PH_SECOND_LABEL,
        PH_HEADER,
        PH_PAYLOAD,
        PH_SKIP
    } t_parse_phase;

    typedef enum logic [2:0] {
        PKT_X, PKT_Y, PKT_T, PKT_L, PKT_C, PKT_F, PKT_B, PKT_E
    } t_packet_kind;

    // Parser state as the block should hold it.
    t_parse_phase phase         = PH_WAIT_LABEL;
    logic [9:0]   byte_pos      = '0;
    t_packet_kind pkt_kind      = PKT_X;
    logic [7:0]   second_label  = '0;
    logic [15:0]  sent_sum      = '0;
    logic [15:0]  running_sum   = '0;
    logic [31:0]  start_index   = '0;
    logic [31:0]  element_count = '0;
    logic [31:0]  word_acc      = '0;
    logic [31:0]  elements_done = '0;

    // Results still owed by the block, oldest first.
    t_out_item expected_q[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_checked = 0;
    end

    function automatic t_out_item make_result(logic [2:0] kind, logic [11:0] idx,
                                              logic [3:0] sid, logic [31:0] data,
                                              logic [2:0] st);
        t_out_item r;
        r.kind          = kind;
        r.element_index = idx;
        r.setting_id    = sid;
        r.data_word     = data;
        r.status        = st;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    function automatic logic is_trigger();
        return pkt_kind == PKT_T && second_label == LBL_A;
    endfunction

    function automatic logic is_stream();
        return pkt_kind == PKT_X || pkt_kind == PKT_Y || is_trigger();
    endfunction

    function automatic logic [2:0] checksum_status();
        return (running_sum == sent_sum) ? ST_OK : ST_CHECKSUM;
    endfunction

    // Setting number selected by the two label bytes of a parameter packet.
    function automatic logic [3:0] setting_number();
        case (pkt_kind)
            PKT_L: return SET_LENGTH;
            PKT_C: return SET_SCANS;
            PKT_F: return SET_LOWPASS;
            PKT_T: begin
                if (second_label == LBL_S) return SET_TSTART;
                if (second_label == LBL_P) return SET_TPERIOD;
                return SET_TLENGTH;
            end
            PKT_B: return (second_label == LBL_X) ? SET_XSTARTV : SET_YSTARTV;
            default: return (second_label == LBL_X) ? SET_XSTOPV : SET_YSTOPV;
        endcase
    endfunction

    // Advance the parser by one byte and queue the results it should cause.
    task automatic predict_byte(input t_in_item item);
        logic [7:0]  b;
        logic        eot;
        logic        done;
        logic        ok;
        logic [9:0]  pos;
        logic [1:0]  emask;
        logic [63:0] need;
        logic [31:0] idx;
        logic [2:0]  kind;
        logic [31:0] data;
        t_out_item   batch[$];
        b    = item.packet_byte;
        eot  = item.end_of_transfer;
        done = 1'b0;
        pos  = byte_pos;

        // Bytes after a finished packet are dropped up to the end of the transfer.
        if (phase == PH_SKIP) begin
            if (eot) phase = PH_WAIT_LABEL;
            return;
        end

        case (phase)
            PH_WAIT_LABEL: begin
                byte_pos      = 10'd1;
                second_label  = '0;
                sent_sum      = '0;
                start_index   = '0;
                element_count = '0;
                word_acc      = '0;
                elements_done = '0;
                running_sum   = {b, 8'h00};
                phase         = PH_SECOND_LABEL;
                case (b)
                    LBL_X: pkt_kind = PKT_X;
                    LBL_Y: pkt_kind = PKT_Y;
                    LBL_T: pkt_kind = PKT_T;
                    LBL_L: pkt_kind = PKT_L;
                    LBL_C: pkt_kind = PKT_C;
                    LBL_F: pkt_kind = PKT_F;
                    LBL_B: pkt_kind = PKT_B;
                    LBL_E: pkt_kind = PKT_E;
                    default: begin
                        pkt_kind = PKT_X;
                        batch.push_back(make_result(KIND_STAT, '0, '0, '0, ST_LABEL));
                        done = 1'b1;
                    end
                endcase
            end
            PH_SECOND_LABEL: begin
                second_label = b;
                running_sum  = running_sum + {8'h00, b};
                ok = 1'b1;
                if (pkt_kind == PKT_T)
                    ok = b inside {LBL_A, LBL_S, LBL_P, LBL_N};
                else if (pkt_kind == PKT_B || pkt_kind == PKT_E)
                    ok = b inside {LBL_X, LBL_Y};
                byte_pos = 10'd2;
                if (ok) begin
                    phase = PH_HEADER;
                end else begin
                    batch.push_back(make_result(KIND_STAT, '0, '0, '0, ST_LABEL));
                    done = 1'b1;
                end
            end
            PH_HEADER: begin
                if (pos == 10'd2) begin
                    sent_sum = {b, 8'h00};
                end else if (pos == 10'd3) begin
                    sent_sum[7:0] = b;
                end else begin
                    running_sum = running_sum + (pos[0] ? {8'h00, b} : {b, 8'h00});
                    if (pos < 10'd8) start_index = {start_index[23:0], b};
                    else             element_count = {element_count[23:0], b};
                end
                byte_pos = pos + 10'd1;
                if (!is_stream() && pos == 10'd7) begin
                    // Parameter packet: the setting only goes out on a matching sum.
                    if (checksum_status() == ST_OK) begin
                        batch.push_back(make_result(KIND_SET, '0, setting_number(),
                                                    start_index, ST_OK));
                        batch.push_back(make_result(KIND_STAT, '0, '0, '0, ST_OK));
                    end else begin
                        batch.push_back(make_result(KIND_STAT, '0, '0, '0, ST_CHECKSUM));
                    end
                    done = 1'b1;
                end else if (is_stream() && pos == 10'd11) begin
                    // Size checks are done on 64 bits so that no count wraps.
                    need = 64'(element_count) * (is_trigger() ? 64'd4 : 64'd2) + 64'd12;
                    if (need > 64'(PACKET_BYTES)) begin
                        batch.push_back(make_result(KIND_STAT, '0, '0, '0, ST_PACKET));
                        done = 1'b1;
                    end else if (64'(start_index) + 64'(element_count)
                                 > 64'(STORE_DEPTH)) begin
                        batch.push_back(make_result(KIND_STAT, '0, '0, '0, ST_STORE));
                        done = 1'b1;
                    end else if (element_count == '0) begin
                        batch.push_back(make_result(KIND_STAT, '0, '0, '0,
                                                    checksum_status()));
                        done = 1'b1;
                    end else begin
                        phase = PH_PAYLOAD;
                    end
                end
            end
            default: begin
                emask       = is_trigger() ? 2'b11 : 2'b01;
                running_sum = running_sum + (pos[0] ? {8'h00, b} : {b, 8'h00});
                word_acc    = {word_acc[23:0], b};
                byte_pos    = pos + 10'd1;
                // Elements start at byte 12, so the low bits of the position
                // tell the last byte of an element.
                if ((pos[1:0] & emask) == emask) begin
                    kind = is_trigger() ? KIND_TRIG : (pkt_kind == PKT_X ? KIND_X : KIND_Y);
                    data = is_trigger() ? word_acc : {16'h0000, word_acc[15:0]};
                    idx  = start_index + elements_done;
                    batch.push_back(make_result(kind, idx[11:0], '0, data, ST_OK));
                    word_acc      = '0;
                    elements_done = elements_done + 32'd1;
                    if (elements_done >= element_count) begin
                        batch.push_back(make_result(KIND_STAT, '0, '0, '0,
                                                    checksum_status()));
                        done = 1'b1;
                    end
                end
            end
        endcase

        if (done) begin
            phase = eot ? PH_WAIT_LABEL : PH_SKIP;
        end else if (eot) begin
            batch.push_back(make_result(KIND_STAT, '0, '0, '0, ST_EARLY));
            phase = PH_WAIT_LABEL;
        end
        if (batch.size() > 0) batch[batch.size() - 1].last_of_run = 1'b1;
        foreach (batch[i]) expected_q.push_back(batch[i]);
    endtask

    // Compare one delivered result with the oldest expected one.
    task automatic check_result(input t_out_item got);
        t_out_item want;
        logic      bad;
        if (expected_q.size() == 0) begin
            o_errors++;
            if (o_errors <= 10)
                $display("ERROR: result with nothing expected: kind %0d idx %0d set %0d data %h st %0d last %0b",
                         got.kind, got.element_index, got.setting_id, got.data_word,
                         got.status, got.last_of_run);
            return;
        end
        want = expected_q.pop_front();
        o_checked++;
        bad = (got.kind != want.kind) || (got.element_index != want.element_index) ||
              (got.setting_id != want.setting_id) || (got.data_word != want.data_word) ||
              (got.status != want.status) || (got.last_of_run != want.last_of_run);
        if (bad) begin
            o_errors++;
            if (o_errors <= 10) begin
                $display("ERROR: expected kind %0d idx %0d set %0d data %h st %0d last %0b",
                         want.kind, want.element_index, want.setting_id, want.data_word,
                         want.status, want.last_of_run);
                $display("       actual   kind %0d idx %0d set %0d data %h st %0d last %0b",
                         got.kind, got.element_index, got.setting_id, got.data_word,
                         got.status, got.last_of_run);
            end
        end
    endtask

    // Watch both channels at each rising edge once reset is released.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) predict_byte(i_in_item);
            if (i_out_valid && i_out_ready) check_result(i_out_item);
        end
        o_pending = expected_q.size();
    end

endmodule

// ===== tb/command_packet_loader_top_tb.sv =====
// Testbench top of the command packet loader: builds packets, drives the byte channel
// under several idle patterns and gives the verdict.
// Depends on cpl_pkg, command_packet_loader_top and cpl_packet_checker.
module command_packet_loader_top_tb
    import cpl_pkg::*;
();

    localparam int STORE_DEPTH  = 4096;
    localparam int PACKET_BYTES = 512;
    localparam int PHASE_BYTES  = 280;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;

    int errors;
    int pending;
    int checked;
    int send_idle_pct;
    int stall_pct;
    int bytes_sent;
    int packets_sent;

    // Bytes of the packet being built.
    logic [7:0] pkt[$];

    // Label pairs of the ten settings, in setting order.
    logic [7:0] set_first[10]  = '{LBL_L, LBL_C, LBL_F, LBL_T, LBL_T,
                                   LBL_T, LBL_B, LBL_B, LBL_E, LBL_E};
    logic [7:0] set_second[10] = '{LBL_L, LBL_C, LBL_F, LBL_S, LBL_P,
                                   LBL_N, LBL_X, LBL_Y, LBL_X, LBL_Y};

    command_packet_loader_top #(
        .STORE_DEPTH (STORE_DEPTH),
        .PACKET_BYTES(PACKET_BYTES)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    cpl_packet_checker #(
        .STORE_DEPTH (STORE_DEPTH),
        .PACKET_BYTES(PACKET_BYTES)
    ) u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_ready (in_ready),
        .i_in_item  (in_item),
        .i_out_valid(out_valid),
        .i_out_ready(out_ready),
        .i_out_item (out_item),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_checked  (checked)
    );

    // Clock with a period of 10.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Receiver stalls at the rate set for the current phase.
    initial out_ready = 1'b0;
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Hard limit on the run time.
    initial begin
        #4000000;
        $display("command_packet_loader_top_tb NOT OK");
        $finish;
    end

    // Offer one byte, with random idle cycles ahead of it, and wait for acceptance.
    task automatic send_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= {b, eot};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    // Send the first n_send bytes of the packet, flagging the last as end of transfer.
    task automatic send_packet(input int n_send, input logic with_eot);
        for (int i = 0; i < n_send; i++)
            send_byte(pkt[i], with_eot && (i == n_send - 1));
        packets_sent++;
    endtask

    // Hold off the sender until every expected result has come out.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic push_word(input logic [31:0] w);
        pkt.push_back(w[31:24]);
        pkt.push_back(w[23:16]);
        pkt.push_back(w[15:8]);
        pkt.push_back(w[7:0]);
    endtask

    task automatic push_noise(input int n);
        for (int i = 0; i < n; i++) pkt.push_back(8'($urandom));
    endtask

    // Fill in the checksum field: sum of big-endian halfwords, field itself excluded.
    task automatic seal_checksum(input logic good);
        logic [15:0] sum;
        sum = '0;
        for (int i = 0; i < pkt.size(); i++) begin
            if (i != 2 && i != 3)
                sum = sum + ((i % 2 == 1) ? {8'h00, pkt[i]} : {pkt[i], 8'h00});
        end
        if (!good) sum = sum ^ 16'($urandom_range(1, 65535));
        pkt[2] = sum[15:8];
        pkt[3] = sum[7:0];
    endtask

    // Labels, checksum, value or start index, then count and random elements for streams.
    task automatic build_packet(input logic [7:0] first, input logic [7:0] second,
                                input logic [31:0] head, input logic stream,
                                input logic [31:0] count, input int n_elem,
                                input int esize, input logic good);
        pkt.delete();
        pkt.push_back(first);
        pkt.push_back(second);
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        push_word(head);
        if (stream) begin
            push_word(count);
            push_noise(n_elem * esize);
        end
        seal_checksum(good);
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Short directed run over the extremes and each special case.
    task automatic run_directed();
        // Smallest writes at both ends of the store.
        build_packet(LBL_X, LBL_X, 32'd0, 1'b1, 32'd1, 1, 2, 1'b1);
        pkt[12] = 8'h00; pkt[13] = 8'h00; seal_checksum(1'b1);
        send_packet(pkt.size(), 1'b1);
        build_packet(LBL_Y, 8'hFF, 32'd4095, 1'b1, 32'd1, 1, 2, 1'b1);
        pkt[12] = 8'hFF; pkt[13] = 8'hFF; seal_checksum(1'b1);
        send_packet(pkt.size(), 1'b1);
        // Trigger words of all ones and all zeros, both halves in the sum.
        build_packet(LBL_T, LBL_A, 32'd10, 1'b1, 32'd2, 2, 4, 1'b1);
        for (int i = 12; i < 16; i++) pkt[i] = 8'hFF;
        for (int i = 16; i < 20; i++) pkt[i] = 8'h00;
        seal_checksum(1'b1);
        send_packet(pkt.size(), 1'b1);
        // Every setting; the first two take values at both extremes.
        for (int i = 0; i < 10; i++) begin
            build_packet(set_first[i], set_second[i],
                         (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom,
                         1'b0, '0, 0, 0, 1'b1);
            send_packet(pkt.size(), 1'b1);
        end
        // Parameter packet with a bad checksum gives only the status.
        build_packet(LBL_L, LBL_L, 32'h1234_5678, 1'b0, '0, 0, 0, 1'b0);
        send_packet(pkt.size(), 1'b1);
        // Zero count, with good and bad checksums.
        build_packet(LBL_X, LBL_X, 32'd7, 1'b1, 32'd0, 0, 2, 1'b1);
        send_packet(pkt.size(), 1'b1);
        build_packet(LBL_T, LBL_A, 32'd7, 1'b1, 32'd0, 0, 4, 1'b0);
        send_packet(pkt.size(), 1'b1);
        // Packet size overruns, including counts whose byte size wraps 32 bits.
        build_packet(LBL_X, LBL_X, 32'd0, 1'b1, 32'd251, 0, 2, 1'b1);
        send_packet(pkt.size(), 1'b1);
        build_packet(LBL_T, LBL_A, 32'd0, 1'b1, 32'h4000_0000, 0, 4, 1'b1);
        send_packet(pkt.size(), 1'b1);
        build_packet(LBL_Y, LBL_Y, 32'd0, 1'b1, 32'h8000_0000, 0, 2, 1'b1);
        send_packet(pkt.size(), 1'b1);
        // Store overruns, including a start index whose sum wraps 32 bits.
        build_packet(LBL_Y, LBL_Y, 32'd4095, 1'b1, 32'd2, 0, 2, 1'b1);
        send_packet(pkt.size(), 1'b1);
        build_packet(LBL_X, LBL_X, 32'hFFFF_FFFF, 1'b1, 32'd1, 0, 2, 1'b1);
        send_packet(pkt.size(), 1'b1);
        // Unknown first label, and second labels that the first one refuses.
        pkt.delete(); pkt.push_back(8'h7A);
        send_packet(1, 1'b1);
        pkt.delete(); pkt.push_back(LBL_E); pkt.push_back(8'h7A);
        send_packet(2, 1'b1);
        pkt.delete(); pkt.push_back(LBL_T); pkt.push_back(8'h71); push_noise(2);
        send_packet(4, 1'b1);
        // Transfer that ends on the byte completing the first element.
        build_packet(LBL_X, LBL_X, 32'd100, 1'b1, 32'd3, 3, 2, 1'b1);
        send_packet(14, 1'b1);
        pkt.delete(); pkt.push_back(LBL_X);
        send_packet(1, 1'b1);
        // Trailing bytes after a finished packet are dropped.
        build_packet(LBL_C, 8'h00, 32'hA5A5_5A5A, 1'b0, '0, 0, 0, 1'b1);
        push_noise(3);
        send_packet(pkt.size(), 1'b1);
        // Largest packet, reaching the last store position.
        build_packet(LBL_X, LBL_X, 32'd3846, 1'b1, 32'd250, 250, 2, 1'b1);
        send_packet(pkt.size(), 1'b1);
    endtask

    // One random packet: mostly well-formed, the rest broken or noise.
    task automatic random_packet();
        int          choice;
        int          sel;
        int          n_elem;
        int          esize;
        int          r;
        logic [7:0]  first;
        logic [7:0]  second;
        logic [7:0]  b;
        logic [31:0] start;
        logic [31:0] count;
        logic        good;
        logic        complete;
        choice   = $urandom_range(99);
        sel      = $urandom_range(2);
        first    = (sel == 0) ? LBL_X : (sel == 1) ? LBL_Y : LBL_T;
        second   = (sel == 2) ? LBL_A : 8'($urandom);
        esize    = (sel == 2) ? 4 : 2;
        good     = ($urandom_range(9) != 0);
        complete = 1'b1;

        if (choice < 45 || (choice >= 89 && choice < 93)) begin
            // Waveform or trigger stream.
            r = $urandom_range(99);
            if (r < 3)
                n_elem = (esize == 2) ? $urandom_range(240, 250) : $urandom_range(120, 125);
            else if (r < 10)
                n_elem = 0;
            else
                n_elem = $urandom_range(1, 6);
            start = ($urandom_range(3) == 0) ? 32'(4096 - n_elem)
                                             : 32'($urandom_range(0, 4096 - n_elem));
            build_packet(first, second, start, 1'b1, 32'(n_elem), n_elem, esize, good);
        end else if (choice < 70 || choice >= 93 && choice < 96) begin
            // Parameter packet.
            sel    = $urandom_range(9);
            second = (sel < 3) ? 8'($urandom) : set_second[sel];
            build_packet(set_first[sel], second, random_value(), 1'b0, '0, 0, 0, good);
        end else if (choice < 75) begin
            // Element bytes would run past the end of the packet.
            case ($urandom_range(3))
                0: count = (esize == 2) ? $urandom_range(251, 4000) : $urandom_range(126, 4000);
                1: count = 32'hFFFF_FFFF;
                2: count = (esize == 2) ? 32'h8000_0000 : 32'h4000_0000;
                default: count = $urandom | 32'h0001_0000;
            endcase
            build_packet(first, second, random_value(), 1'b1, count, 0, esize, good);
        end else if (choice < 80) begin
            // Elements would run past the end of the store.
            n_elem = $urandom_range(1, 6);
            start  = $urandom_range(1) ? 32'(4097 - n_elem + $urandom_range(0, 3))
                                       : ($urandom | 32'h8000_0000);
            build_packet(first, second, start, 1'b1, 32'(n_elem), 0, esize, good);
        end else if (choice < 85) begin
            // First byte that is no label.
            do b = 8'($urandom);
            while (b inside {LBL_X, LBL_Y, LBL_T, LBL_L, LBL_C, LBL_F, LBL_B, LBL_E});
            pkt.delete();
            pkt.push_back(b);
            push_noise($urandom_range(0, 3));
        end else if (choice < 89) begin
            // Second label refused by the first.
            pkt.delete();
            case ($urandom_range(2))
                0: begin
                    do b = 8'($urandom); while (b inside {LBL_A, LBL_S, LBL_P, LBL_N});
                    pkt.push_back(LBL_T);
                end
                1: begin
                    do b = 8'($urandom); while (b inside {LBL_X, LBL_Y});
                    pkt.push_back(LBL_B);
                end
                default: begin
                    do b = 8'($urandom); while (b inside {LBL_X, LBL_Y});
                    pkt.push_back(LBL_E);
                end
            endcase
            pkt.push_back(b);
            push_noise($urandom_range(0, 3));
        end else begin
            // Noise burst.
            pkt.delete();
            push_noise($urandom_range(1, 6));
        end

        // Streams and parameter packets in the ended-early bands are cut short.
        if (choice >= 89 && choice < 96) begin
            complete = 1'b0;
            send_packet($urandom_range(1, pkt.size() - 1), 1'b1);
        end
        if (complete) begin
            r = $urandom_range(99);
            if (r < 12) push_noise($urandom_range(1, 3));
            send_packet(pkt.size(), !(r >= 12 && r < 15));
        end
    endtask

    // Main sequence: reset, directed packets, then four random phases.
    initial begin
        int   phase_start;
        logic paused;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_item       = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        bytes_sent    = 0;
        packets_sent  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 84; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 84; end
                default: begin send_idle_pct = 22; stall_pct = 22; end
            endcase
            phase_start = bytes_sent;
            paused      = 1'b0;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                random_packet();
                if (!paused && bytes_sent - phase_start >= PHASE_BYTES / 2) begin
                    wait_for_drain();
                    paused = 1'b1;
                end
            end
        end

        // Let every owed result come out.
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (16) @(posedge clk);

        $display("Sent %0d bytes in %0d packets under four idle patterns.",
                 bytes_sent, packets_sent);
        $display("Checked %0d results, %0d mismatches.", checked, errors);
        if (errors == 0 && pending == 0)
            $display("command_packet_loader_top_tb OK");
        else
            $display("command_packet_loader_top_tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/cpl_pkg.sv
sv/cpl_parser.sv
sv/cpl_fifo.sv
sv/command_packet_loader_top.sv
tb/cpl_packet_checker.sv
tb/command_packet_loader_top_tb.sv
